// ===== sv/wfr_pkg.sv =====
// Shared types and constants for the WebSocket frame receiver.
// No dependencies; imported by the parser, queue, emitter and top level.
package wfr_pkg;

  // Default width of the payload byte counter
  localparam int unsigned PAYLOAD_COUNT_BITS_DEF = 26;
  // Width and reset value of the maximum-length register
  localparam int unsigned MAX_LEN_BITS = 26;
  localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = 26'h2000000;

  // Opcodes 3..7 and 11..15 are reserved
  localparam logic [15:0] RESERVED_OPS = 16'hF8F8;

  // Header field masks and short-length escapes
  localparam logic [7:0] RSV_MASK  = 8'h70;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Opcodes that the parser acts on
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Depth of the queue between parser and emitter
  localparam int unsigned QUEUE_DEPTH = 4;

  // Result event codes
  typedef enum logic [3:0] {
    EV_BYTE      = 4'd0,
    EV_EMPTY     = 4'd1,
    EV_PING      = 4'd2,
    EV_PONG      = 4'd3,
    EV_CLOSE     = 4'd4,
    EV_RSV_ERR   = 4'd5,
    EV_OP_ERR    = 4'd6,
    EV_LEN_ERR   = 4'd7,
    EV_CONT_ERR  = 4'd8
  } event_t;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXT     = 6'b000100,
    PH_KEY     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_STOP    = 6'b100000
  } phase_t;

  // One classified word handed from parser to emitter
  typedef struct packed {
    event_t     ev;
    logic [7:0] raw;       // received byte, zero for non-byte events
    logic [7:0] key;       // mask byte to apply, zero when unmasked
    logic [3:0] opcode;
    logic [1:0] msg_type;
    logic       fin;
    logic       last;
  } entry_t;

endpackage

// ===== sv/wfr_parser.sv =====
// Front end: frame header parser and payload classifier.
// Depends on wfr_pkg; produces at most one entry_t word per accepted byte.
module wfr_parser #(
  parameter int unsigned PAYLOAD_COUNT_BITS = wfr_pkg::PAYLOAD_COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [wfr_pkg::MAX_LEN_BITS-1:0] cfg_data,
  input  logic                             take,
  input  logic [7:0]                       rx_byte,
  output logic                             push,
  output wfr_pkg::entry_t                  push_word
);
  import wfr_pkg::*;

  localparam int unsigned PCB = PAYLOAD_COUNT_BITS;
  localparam int unsigned CW  = (PCB > MAX_LEN_BITS) ? PCB : MAX_LEN_BITS;

  logic [MAX_LEN_BITS-1:0] max_len;
  phase_t                  phase, phase_next;
  logic                    fin_bit, fin_bit_next;
  logic [3:0]              cur_opcode, cur_opcode_next;
  logic                    masked, masked_next;
  logic                    wide_len, wide_len_next;
  logic [3:0]              ext_left, ext_left_next;
  logic [PCB-1:0]          accum, accum_next;
  logic                    accum_high, accum_high_next;
  logic [31:0]             mask_key, mask_key_next;
  logic [PCB-1:0]          payload_left, payload_left_next;
  logic [1:0]              mask_index, mask_index_next;
  logic                    in_frag, in_frag_next;
  logic [1:0]              frag_type, frag_type_next;

  logic                    emit;
  entry_t                  word;
  logic                    len_done, hdr_done, len_err;
  logic [6:0]              len7;
  logic [1:0]              key_idx;
  logic [CW-1:0]           accum_cmp, max_cmp;

  assign len7    = rx_byte[6:0];
  assign key_idx = 2'(4'd4 - ext_left);

  // Next-state and result classification for one byte
  always_comb begin
    phase_next        = phase;
    fin_bit_next      = fin_bit;
    cur_opcode_next   = cur_opcode;
    masked_next       = masked;
    wide_len_next     = wide_len;
    ext_left_next     = ext_left;
    accum_next        = accum;
    accum_high_next   = accum_high;
    mask_key_next     = mask_key;
    payload_left_next = payload_left;
    mask_index_next   = mask_index;
    in_frag_next      = in_frag;
    frag_type_next    = frag_type;
    emit              = 1'b0;
    word              = '0;
    len_done          = 1'b0;
    hdr_done          = 1'b0;
    len_err           = 1'b0;
    accum_cmp         = '0;
    max_cmp           = CW'(max_len);

    unique case (phase)
      PH_HDR0: begin
        fin_bit_next    = rx_byte[7];
        cur_opcode_next = rx_byte[3:0];
        if ((rx_byte & RSV_MASK) != 8'h00) begin
          phase_next = PH_STOP;
          emit       = 1'b1;
          word.ev    = EV_RSV_ERR;
        end else if (RESERVED_OPS[rx_byte[3:0]]) begin
          phase_next = PH_STOP;
          emit       = 1'b1;
          word.ev    = EV_OP_ERR;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        masked_next     = rx_byte[7];
        accum_next      = '0;
        accum_high_next = 1'b0;
        mask_key_next   = '0;
        mask_index_next = '0;
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          wide_len_next = (len7 == LEN_EXT64);
          ext_left_next = (len7 == LEN_EXT64) ? 4'd8 : 4'd2;
          phase_next    = PH_EXT;
        end else begin
          wide_len_next     = 1'b0;
          payload_left_next = PCB'(len7);
          len_done          = 1'b1;
        end
      end
      PH_EXT: begin
        // Bytes pushed out of the counter width mark an oversize length
        accum_high_next = accum_high | (accum[PCB-1 -: 8] != 8'h00);
        accum_next      = {accum[PCB-9:0], rx_byte};
        ext_left_next   = ext_left - 4'd1;
        accum_cmp       = CW'(accum_next);
        if (ext_left_next == 4'd0) begin
          len_err = accum_high_next || (wide_len && accum_cmp > max_cmp);
          if (len_err) begin
            phase_next = PH_STOP;
            emit       = 1'b1;
            word.ev    = EV_LEN_ERR;
          end else begin
            payload_left_next = accum_next;
            len_done          = 1'b1;
          end
        end
      end
      PH_KEY: begin
        mask_key_next[{key_idx, 3'b000} +: 8] = rx_byte;
        ext_left_next = ext_left - 4'd1;
        hdr_done      = (ext_left_next == 4'd0);
      end
      PH_PAYLOAD: begin
        mask_index_next = mask_index + 2'd1;
        if (payload_left != '0) begin
          payload_left_next = payload_left - PCB'(1);
        end
        if (payload_left_next == '0) begin
          phase_next = PH_HDR0;
        end
        // Control frame payload is swallowed
        if (!cur_opcode[3]) begin
          emit      = 1'b1;
          word.ev   = EV_BYTE;
          word.raw  = rx_byte;
          word.key  = masked ? mask_key[{mask_index, 3'b000} +: 8] : 8'h00;
          word.last = (payload_left_next == '0);
        end
      end
      PH_STOP: begin
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase

    // Length complete: masking key next, or header complete
    if (len_done) begin
      if (masked_next) begin
        ext_left_next = 4'd4;
        phase_next    = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: fragment tracking and frame-level events
    if (hdr_done) begin
      if (cur_opcode == OP_CONT && !in_frag) begin
        phase_next = PH_STOP;
        emit       = 1'b1;
        word.ev    = EV_CONT_ERR;
      end else begin
        if (cur_opcode == OP_TEXT || cur_opcode == OP_BINARY) begin
          in_frag_next = !fin_bit;
          if (!fin_bit) begin
            frag_type_next = cur_opcode[1:0];
          end
        end else if (cur_opcode == OP_CONT && fin_bit) begin
          in_frag_next = 1'b0;
        end
        if (cur_opcode == OP_CLOSE) begin
          phase_next = PH_STOP;
          emit       = 1'b1;
          word.ev    = EV_CLOSE;
        end else if (cur_opcode == OP_PING || cur_opcode == OP_PONG) begin
          phase_next = (payload_left_next != '0) ? PH_PAYLOAD : PH_HDR0;
          emit       = 1'b1;
          word.ev    = (cur_opcode == OP_PING) ? EV_PING : EV_PONG;
        end else if (payload_left_next == '0) begin
          phase_next = PH_HDR0;
          emit       = 1'b1;
          word.ev    = EV_EMPTY;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end

    // Frame-level fields common to every result
    word.opcode   = cur_opcode_next;
    word.fin      = fin_bit_next;
    word.msg_type = 2'b00;
    if (word.ev == EV_BYTE || word.ev == EV_EMPTY) begin
      word.msg_type = (cur_opcode_next == OP_CONT) ? frag_type_next
                                                   : cur_opcode_next[1:0];
    end
  end

  assign push      = take && emit;
  assign push_word = word;

  // Parser control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      fin_bit    <= 1'b0;
      cur_opcode <= '0;
      masked     <= 1'b0;
      wide_len   <= 1'b0;
      ext_left   <= '0;
      accum      <= '0;
      accum_high <= 1'b0;
      mask_key   <= '0;
      payload_left <= '0;
      mask_index <= '0;
      in_frag    <= 1'b0;
      frag_type  <= '0;
    end else if (take) begin
      phase      <= phase_next;
      fin_bit    <= fin_bit_next;
      cur_opcode <= cur_opcode_next;
      masked     <= masked_next;
      wide_len   <= wide_len_next;
      ext_left   <= ext_left_next;
      accum      <= accum_next;
      accum_high <= accum_high_next;
      mask_key   <= mask_key_next;
      payload_left <= payload_left_next;
      mask_index <= mask_index_next;
      in_frag    <= in_frag_next;
      frag_type  <= frag_type_next;
    end
  end

  // Length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_len <= cfg_data;
    end
  end

`ifndef ASSERT_OFF
  // Once stopped, only reset restarts parsing
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STOP |=> phase == PH_STOP)
    else $error("parser left the stopped phase");

  // Key bytes are only collected for masked frames
  a_key_masked: assert property (@(posedge clk) disable iff (rst)
    phase == PH_KEY |-> masked)
    else $error("key phase on an unmasked frame");

  // Payload phase always has bytes outstanding
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_left != '0)
    else $error("payload phase with nothing left");
`endif

endmodule

// ===== sv/wfr_queue.sv =====
// Short word queue decoupling the parser from the emitter.
// Depends on wfr_pkg for entry_t and QUEUE_DEPTH.
module wfr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wfr_pkg::entry_t push_word,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output wfr_pkg::entry_t head
);
  import wfr_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  entry_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;

  assign full      = (count == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/wfr_emitter.sv =====
// Back end: unmasks payload bytes and holds the result word for the sink.
// Depends on wfr_pkg for entry_t.
module wfr_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  wfr_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [3:0]      event_res,
  output logic [7:0]      data,
  output logic [3:0]      frame_opcode,
  output logic [1:0]      message_type,
  output logic            final_fragment,
  output logic            last_in_frame
);
  import wfr_pkg::*;

  // Load a new word whenever the output register is free or being taken
  assign q_pop = q_not_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      event_res      <= q_head.ev;
      data           <= q_head.raw ^ q_head.key;
      frame_opcode   <= q_head.opcode;
      message_type   <= q_head.msg_type;
      final_fragment <= q_head.fin;
      last_in_frame  <= q_head.last;
    end
  end

endmodule

// ===== sv/websocket_frame_receiver.sv =====
// Top level of the WebSocket frame receiver: parser, queue, emitter.
// Depends on wfr_pkg, wfr_parser, wfr_queue and wfr_emitter.
//
//  port group        direction  handshake              words
//  rx_byte           in         in_valid / in_ready    one received byte
//  event_res..last   out        out_valid / out_ready  zero or one result per byte
//  cfg_data          in         cfg_write              maximum 26-bit length
//
// One byte is taken per clock while the four-word queue has room; the header
// parser updates only small registers, so it has no busy state and never holds a byte.
// A result passes from its byte through the queue write, then the output register.
// Reset (rst, synchronous) returns the parser to the first header byte.
// A stalled sink fills the queue and then drops in_ready; after an error or
// close, bytes are still taken but give no result until reset.
module websocket_frame_receiver #(
  parameter int unsigned PAYLOAD_COUNT_BITS = wfr_pkg::PAYLOAD_COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [wfr_pkg::MAX_LEN_BITS-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       event_res,
  output logic [7:0]                       data,
  output logic [3:0]                       frame_opcode,
  output logic [1:0]                       message_type,
  output logic                             final_fragment,
  output logic                             last_in_frame
);
  import wfr_pkg::*;

  logic   take;
  logic   push;
  entry_t push_word;
  logic   q_full;
  logic   q_pop;
  logic   q_not_empty;
  entry_t q_head;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Front: header parsing and classification
  wfr_parser #(
    .PAYLOAD_COUNT_BITS(PAYLOAD_COUNT_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .take     (take),
    .rx_byte  (rx_byte),
    .push     (push),
    .push_word(push_word)
  );

  // Decoupling queue
  wfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_word(push_word),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  // Back: unmasking and output register
  wfr_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .data          (data),
    .frame_opcode  (frame_opcode),
    .message_type  (message_type),
    .final_fragment(final_fragment),
    .last_in_frame (last_in_frame)
  );

endmodule
